### hw/rtl/bbect_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bbect_pkg;

  // widths of the word fields
  localparam int BYTE_BITS   = 8;
  localparam int OPCODE_W    = 3;
  localparam int USER_W      = 4;
  localparam int SLOT_W      = 6;
  localparam int SYMBITS_W   = 4;
  localparam int AMOUNT_W    = 16;
  localparam int RESULT_W    = 32;
  localparam int ERRCOUNT_W  = 4;

  // event opcodes, any other code reads
  localparam logic [OPCODE_W-1:0] OP_CODED_ERR   = 3'd0;
  localparam logic [OPCODE_W-1:0] OP_DEC_BITS    = 3'd1;
  localparam logic [OPCODE_W-1:0] OP_BLOCK_REP   = 3'd2;
  localparam logic [OPCODE_W-1:0] OP_COUNT_BLOCK = 3'd3;
  localparam logic [OPCODE_W-1:0] OP_RAW_ERR     = 3'd4;
  localparam logic [OPCODE_W-1:0] OP_RAW_BITS    = 3'd5;
  localparam logic [OPCODE_W-1:0] OP_READ        = 3'd6;

  typedef struct packed {
    logic [OPCODE_W-1:0]   opcode;
    logic [USER_W-1:0]     user_index;
    logic [SLOT_W-1:0]     slot_index;
    logic [BYTE_BITS-1:0]  sent_byte;
    logic [BYTE_BITS-1:0]  received_byte;
    logic [SYMBITS_W-1:0]  symbol_bits;
    logic [AMOUNT_W-1:0]   amount;
  } item_t;

  typedef struct packed {
    logic [RESULT_W-1:0]   coded_bit_errors;
    logic [RESULT_W-1:0]   decoded_bits;
    logic [RESULT_W-1:0]   block_errors;
    logic [RESULT_W-1:0]   decoded_blocks;
    logic [RESULT_W-1:0]   raw_bit_errors;
    logic [RESULT_W-1:0]   raw_bits;
    logic [ERRCOUNT_W-1:0] errors_this_item;
  } result_t;

  // differing bits among the lowest nbits of two bytes (nbits above 8 means all)
  function automatic logic [ERRCOUNT_W-1:0] count_low_diff(
    input logic [BYTE_BITS-1:0] a,
    input logic [BYTE_BITS-1:0] b,
    input logic [SYMBITS_W-1:0] nbits
  );
    logic [BYTE_BITS-1:0]  x;
    logic [ERRCOUNT_W-1:0] n;
    x = a ^ b;
    n = '0;
    for (int j = 0; j < BYTE_BITS; j++) begin
      if (SYMBITS_W'(j) < nbits) begin
        n = n + ERRCOUNT_W'(x[j]);
      end
    end
    return n;
  endfunction

endpackage

`default_nettype wire

### hw/rtl/bbect_if.sv
`timescale 1ns / 1ps
`default_nettype none

// event channel
interface bbect_in_if import bbect_pkg::*; ();
  logic  valid;
  logic  ready;
  item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// result channel
interface bbect_out_if import bbect_pkg::*; ();
  logic    valid;
  logic    ready;
  result_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

### hw/rtl/bbect_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module bbect_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 192,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic              re,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port, old data on a same-address collision
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### hw/rtl/bit_block_error_counter_table_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// Stages: memory read into the update stage, then the update into the output register.
// Throughput: one word per cycle unless the output stalls; the counter memory's single
// read and write port carry one read-modify-write per word, with a same-address forward
// between neighbors. Reset: synchronous, active low; afterwards a clearing pass zeroes
// the table, one slot per cycle, and no word is accepted until it ends.
module bit_block_error_counter_table_unit import bbect_pkg::*; #(
  parameter int USER_COUNT    = 16,
  parameter int SLOT_COUNT    = 64,
  parameter int COUNTER_WIDTH = 32
) (
  input wire logic     clk,
  input wire logic     rst_n,
  bbect_in_if.sink     in_if,
  bbect_out_if.source  out_if
);

  localparam int ENTRY_COUNT = USER_COUNT * SLOT_COUNT;
  localparam int ADDR_W      = (ENTRY_COUNT > 1) ? $clog2(ENTRY_COUNT) : 1;
  localparam int SUM_W       = ((COUNTER_WIDTH > AMOUNT_W) ? COUNTER_WIDTH : AMOUNT_W) + 1;

  typedef logic [COUNTER_WIDTH-1:0] cnt_t;

  typedef struct packed {
    cnt_t coded_err;
    cnt_t dec_bits;
    cnt_t block_err;
    cnt_t dec_blocks;
    cnt_t raw_err;
    cnt_t raw_bits;
  } slot_t;

  localparam cnt_t CNT_MAX = '1;

  function automatic cnt_t sat_add(input cnt_t v, input logic [AMOUNT_W-1:0] a);
    logic [SUM_W-1:0] s;
    s = SUM_W'(v) + SUM_W'(a);
    return (s > SUM_W'(CNT_MAX)) ? CNT_MAX : cnt_t'(s);
  endfunction

  // clearing pass
  logic              clearing_r;
  logic [ADDR_W-1:0] clr_cnt_r;

  // update stage
  logic                  s1_valid_r;
  logic                  s1_inrange_r;
  logic [OPCODE_W-1:0]   s1_op_r;
  logic [ADDR_W-1:0]     s1_addr_r;
  logic [AMOUNT_W-1:0]   s1_addend_r;
  logic [ERRCOUNT_W-1:0] s1_errs_r;
  logic                  fwd_hit_r;
  slot_t                 fwd_data_r;

  // output register
  logic    out_valid_r;
  result_t out_data_r;

  logic                  in_fire;
  logic                  s1_adv;
  logic                  in_range;
  logic [ADDR_W-1:0]     in_addr;
  logic [ERRCOUNT_W-1:0] in_errs;
  logic [AMOUNT_W-1:0]   in_addend;
  logic                  s1_we;
  slot_t                 rd_data;
  slot_t                 cur;
  slot_t                 upd;
  result_t               res;
  logic                  mem_we;
  logic [ADDR_W-1:0]     mem_waddr;
  slot_t                 mem_wdata;

  assign s1_adv      = s1_valid_r && (!out_valid_r || out_if.ready);
  assign in_if.ready = !clearing_r && (!s1_valid_r || s1_adv);
  assign in_fire     = in_if.valid && in_if.ready;
  assign s1_we       = s1_adv && s1_inrange_r;

  // decode of the incoming word
  always_comb begin
    in_range = (32'(in_if.data.user_index) < USER_COUNT) &&
               (32'(in_if.data.slot_index) < SLOT_COUNT);
    in_addr  = ADDR_W'(32'(in_if.data.user_index) * SLOT_COUNT +
                       32'(in_if.data.slot_index));
    in_errs  = '0;
    if (in_if.data.opcode == OP_CODED_ERR) begin
      in_errs = count_low_diff(in_if.data.sent_byte, in_if.data.received_byte,
                               SYMBITS_W'(BYTE_BITS));
    end else if (in_if.data.opcode == OP_RAW_ERR) begin
      in_errs = count_low_diff(in_if.data.sent_byte, in_if.data.received_byte,
                               in_if.data.symbol_bits);
    end
    unique case (in_if.data.opcode)
      OP_CODED_ERR, OP_RAW_ERR: in_addend = AMOUNT_W'(in_errs);
      OP_DEC_BITS, OP_RAW_BITS: in_addend = in_if.data.amount;
      OP_BLOCK_REP:             in_addend = AMOUNT_W'(in_if.data.amount != '0);
      OP_COUNT_BLOCK:           in_addend = AMOUNT_W'(1);
      default:                  in_addend = '0;
    endcase
  end

  // counter memory
  assign mem_we    = clearing_r || s1_we;
  assign mem_waddr = clearing_r ? clr_cnt_r : s1_addr_r;
  assign mem_wdata = clearing_r ? '0 : upd;

  bbect_ram #(
    .DEPTH (ENTRY_COUNT),
    .WIDTH ($bits(slot_t)),
    .ADDR_W(ADDR_W)
  ) u_ram (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .re   (in_fire),
    .raddr(in_addr),
    .rdata(rd_data)
  );

  // read-modify-write of the addressed slot
  always_comb begin
    cur = fwd_hit_r ? fwd_data_r : rd_data;
    upd = cur;
    unique case (s1_op_r)
      OP_CODED_ERR:   upd.coded_err  = sat_add(cur.coded_err, s1_addend_r);
      OP_DEC_BITS:    upd.dec_bits   = sat_add(cur.dec_bits, s1_addend_r);
      OP_BLOCK_REP:   upd.block_err  = sat_add(cur.block_err, s1_addend_r);
      OP_COUNT_BLOCK: upd.dec_blocks = sat_add(cur.dec_blocks, s1_addend_r);
      OP_RAW_ERR:     upd.raw_err    = sat_add(cur.raw_err, s1_addend_r);
      OP_RAW_BITS:    upd.raw_bits   = sat_add(cur.raw_bits, s1_addend_r);
      default:        upd = cur;
    endcase
    res = '0;
    if (s1_inrange_r) begin
      res.coded_bit_errors = RESULT_W'(upd.coded_err);
      res.decoded_bits     = RESULT_W'(upd.dec_bits);
      res.block_errors     = RESULT_W'(upd.block_err);
      res.decoded_blocks   = RESULT_W'(upd.dec_blocks);
      res.raw_bit_errors   = RESULT_W'(upd.raw_err);
      res.raw_bits         = RESULT_W'(upd.raw_bits);
      res.errors_this_item = s1_errs_r;
    end
  end

  // control and stage registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r  <= 1'b1;
      clr_cnt_r   <= '0;
      s1_valid_r  <= 1'b0;
      fwd_hit_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (clearing_r) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
        if (clr_cnt_r == ADDR_W'(ENTRY_COUNT - 1)) begin
          clearing_r <= 1'b0;
        end
      end
      if (in_fire) begin
        s1_valid_r <= 1'b1;
        fwd_hit_r  <= s1_we && (s1_addr_r == in_addr);
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_r <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_inrange_r <= in_range;
      s1_op_r      <= in_if.data.opcode;
      s1_addr_r    <= in_addr;
      s1_addend_r  <= in_addend;
      s1_errs_r    <= in_errs;
      fwd_data_r   <= upd;
    end
    if (s1_adv) begin
      out_data_r <= res;
    end
  end

  assign out_if.valid = out_valid_r;
  assign out_if.data  = out_data_r;

  // no word enters while the table is being cleared
  a_no_accept_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    clearing_r |-> !in_fire)
    else $error("word accepted during clearing pass");

  // the update stage is empty while clearing
  a_stage_empty_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    clearing_r |-> !s1_valid_r)
    else $error("update stage busy during clearing pass");

  // a slot outside the table is never written
  a_no_write_out_of_range: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && !s1_inrange_r && !clearing_r) |-> !mem_we)
    else $error("write for an address outside the table");

  // a finished update appears at the output in the next cycle
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv |=> out_valid_r)
    else $error("result lost after update");

endmodule

`default_nettype wire

### bench/tb_bit_block_error_counter_table_unit.sv
`timescale 1ns / 1ps
`default_nettype none

module tb_bit_block_error_counter_table_unit;
  import bbect_pkg::*;

  localparam int USERS       = 16;
  localparam int SLOTS       = 64;
  localparam int ENTRIES     = USERS * SLOTS;
  localparam int ADDR_W      = USER_W + SLOT_W;
  localparam int HOT_COUNT   = 8;
  localparam int STALL_LIMIT = 5000;
  localparam int HOLD_CYCLES = 80;
  localparam int BIG_ROUNDS  = 8;
  localparam int MAX_REPORTS = 100;

  // code outside the named events, reads like OP_READ
  localparam logic [OPCODE_W-1:0] OP_SPARE = 3'd7;

  logic clk = 1'b0;
  logic rst_n;

  bbect_in_if  in_ch ();
  bbect_out_if out_ch ();

  bit_block_error_counter_table_unit #(
    .USER_COUNT   (USERS),
    .SLOT_COUNT   (SLOTS),
    .COUNTER_WIDTH(RESULT_W)
  ) u_top (
    .clk   (clk),
    .rst_n (rst_n),
    .in_if (in_ch),
    .out_if(out_ch)
  );

  always #5 clk = ~clk;

  // shadow copy of the six counter tables
  logic [RESULT_W-1:0] coded_err_tbl  [ENTRIES];
  logic [RESULT_W-1:0] dec_bits_tbl   [ENTRIES];
  logic [RESULT_W-1:0] blk_err_tbl    [ENTRIES];
  logic [RESULT_W-1:0] dec_blocks_tbl [ENTRIES];
  logic [RESULT_W-1:0] raw_err_tbl    [ENTRIES];
  logic [RESULT_W-1:0] raw_bits_tbl   [ENTRIES];

  result_t expected_counts_q [$];

  int failures      = 0;
  int words_sent    = 0;
  int words_checked = 0;
  int idle_cycles   = 0;

  bit gap_en   = 1'b0;
  bit stall_en = 1'b0;
  bit hold_req = 1'b0;

  logic [ADDR_W-1:0] hot_addr [HOT_COUNT];
  logic [ADDR_W-1:0] last_addr = '0;

  // saturating counter add
  function automatic logic [RESULT_W-1:0] sat_add(input logic [RESULT_W-1:0] v,
                                                  input logic [RESULT_W-1:0] a);
    logic [RESULT_W:0] s;
    s = {1'b0, v} + {1'b0, a};
    return s[RESULT_W] ? '1 : s[RESULT_W-1:0];
  endfunction

  // bit errors among the lowest nbits of the two bytes, capped at a full byte
  function automatic logic [ERRCOUNT_W-1:0] diff_bits(input logic [BYTE_BITS-1:0] a,
                                                      input logic [BYTE_BITS-1:0] b,
                                                      input logic [SYMBITS_W-1:0] nbits);
    logic [BYTE_BITS-1:0] x;
    int lim;
    int n;
    x   = a ^ b;
    lim = (nbits > BYTE_BITS) ? BYTE_BITS : int'(nbits);
    n   = 0;
    for (int j = 0; j < lim; j++) n += x[j];
    return n[ERRCOUNT_W-1:0];
  endfunction

  // apply one event to the shadow tables and return the slot's counters
  function automatic result_t predict_slot_update(input item_t w);
    result_t r;
    int k;
    logic [ERRCOUNT_W-1:0] errs;
    r    = '0;
    errs = '0;
    if (w.user_index >= USERS || w.slot_index >= SLOTS) return r;
    k = w.user_index * SLOTS + w.slot_index;
    case (w.opcode)
      OP_CODED_ERR: begin
        errs = diff_bits(w.sent_byte, w.received_byte, SYMBITS_W'(BYTE_BITS));
        coded_err_tbl[k] = sat_add(coded_err_tbl[k], RESULT_W'(errs));
      end
      OP_DEC_BITS:    dec_bits_tbl[k] = sat_add(dec_bits_tbl[k], RESULT_W'(w.amount));
      OP_BLOCK_REP:   blk_err_tbl[k] = sat_add(blk_err_tbl[k], RESULT_W'(w.amount != 0));
      OP_COUNT_BLOCK: dec_blocks_tbl[k] = sat_add(dec_blocks_tbl[k], RESULT_W'(1));
      OP_RAW_ERR: begin
        errs = diff_bits(w.sent_byte, w.received_byte, w.symbol_bits);
        raw_err_tbl[k] = sat_add(raw_err_tbl[k], RESULT_W'(errs));
      end
      OP_RAW_BITS:    raw_bits_tbl[k] = sat_add(raw_bits_tbl[k], RESULT_W'(w.amount));
      default: ;
    endcase
    r.coded_bit_errors = coded_err_tbl[k];
    r.decoded_bits     = dec_bits_tbl[k];
    r.block_errors     = blk_err_tbl[k];
    r.decoded_blocks   = dec_blocks_tbl[k];
    r.raw_bit_errors   = raw_err_tbl[k];
    r.raw_bits         = raw_bits_tbl[k];
    r.errors_this_item = errs;
    return r;
  endfunction

  // random event, biased toward a few busy slots and back-to-back repeats
  function automatic item_t next_random_word();
    item_t w;
    logic [ADDR_W-1:0] a;
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 2) a = last_addr;
    else if (pick < 7) a = hot_addr[$urandom_range(0, HOT_COUNT - 1)];
    else a = ADDR_W'($urandom);
    last_addr                   = a;
    w.opcode                    = OPCODE_W'($urandom_range(0, 7));
    {w.user_index, w.slot_index} = a;
    w.sent_byte                 = BYTE_BITS'($urandom);
    w.received_byte             = BYTE_BITS'($urandom);
    w.symbol_bits               = SYMBITS_W'($urandom_range(0, 15));
    case ($urandom_range(0, 3))
      0:       w.amount = '0;
      1:       w.amount = '1;
      default: w.amount = AMOUNT_W'($urandom);
    endcase
    return w;
  endfunction

  // offer one word, record its expected counters once it is taken
  task automatic send_word(input item_t w);
    in_ch.valid <= 1'b1;
    in_ch.data  <= w;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    expected_counts_q.push_back(predict_slot_update(w));
    words_sent++;
    if (gap_en && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  // stop offering and wait for every outstanding result
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (expected_counts_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // every opcode, byte and amount extremes, symbol width corners, table corners
  task automatic test_directed_events();
    item_t w;
    w        = '0;
    gap_en   = 1'b0;
    stall_en = 1'b0;
    w.opcode = OP_CODED_ERR;
    w.sent_byte = 8'h00; w.received_byte = 8'hFF; send_word(w);
    w.sent_byte = 8'hA5; w.received_byte = 8'hA5; send_word(w);
    w.opcode = OP_DEC_BITS;
    w.amount = '1; send_word(w);
    w.amount = '0; send_word(w);
    w.opcode = OP_BLOCK_REP;
    send_word(w);
    w.amount = 16'h8000; send_word(w);
    w.amount = 16'h0001; send_word(w);
    w.opcode = OP_COUNT_BLOCK;
    send_word(w);
    send_word(w);
    // uncoded errors: zero width, partial, full byte, width above a byte
    w.opcode = OP_RAW_ERR;
    w.sent_byte = 8'hFF; w.received_byte = 8'h00;
    w.symbol_bits = 4'd0;  send_word(w);
    w.symbol_bits = 4'd3;  send_word(w);
    w.symbol_bits = 4'd8;  send_word(w);
    w.symbol_bits = 4'd15; send_word(w);
    w.opcode = OP_RAW_BITS;
    w.amount = '1; send_word(w);
    w.opcode = OP_READ;  send_word(w);
    w.opcode = OP_SPARE; send_word(w);
    // far corners of the table
    w.user_index = '1; w.slot_index = '1;
    w.opcode = OP_CODED_ERR; w.sent_byte = 8'h0F; w.received_byte = 8'hF0; send_word(w);
    w.opcode = OP_READ; send_word(w);
    w.slot_index = '0;
    w.opcode = OP_COUNT_BLOCK; send_word(w);
    w.user_index = '0; w.slot_index = '1;
    send_word(w);
    drain_results();
  endtask

  // receiver holds off while words keep coming, then the sender waits it out
  task automatic test_output_hold();
    gap_en   = 1'b0;
    stall_en = 1'b0;
    hold_req = 1'b1;
    repeat (40) send_word(next_random_word());
    drain_results();
  endtask

  // random traffic with random idling phases, the tail with none
  task automatic test_random_traffic(input int count);
    for (int i = 0; i < count; i++) begin
      if (i % 100 == 0) begin
        gap_en   = (count - i > 300) && ($urandom_range(0, 2) != 0);
        stall_en = (count - i > 300) && ($urandom_range(0, 2) != 0);
      end
      send_word(next_random_word());
    end
    drain_results();
  endtask

  // full-scale bit counts piling up in one slot, back to back
  task automatic test_large_amounts();
    item_t w;
    w            = '0;
    w.user_index = 4'd9;
    w.slot_index = 6'd33;
    w.amount     = '1;
    gap_en       = 1'b0;
    stall_en     = 1'b0;
    for (int i = 0; i < BIG_ROUNDS; i++) begin
      w.opcode = OP_DEC_BITS; send_word(w);
      w.opcode = OP_RAW_BITS; send_word(w);
    end
    w.opcode = OP_READ;
    send_word(w);
    drain_results();
  endtask

  function automatic void check_field(input string name,
                                      input logic [RESULT_W-1:0] exp_v,
                                      input logic [RESULT_W-1:0] got_v);
    if (got_v !== exp_v) begin
      if (failures < MAX_REPORTS)
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, got_v);
      failures++;
    end
  endfunction

  // result checker
  always @(posedge clk) begin
    result_t exp_r;
    result_t got;
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      got = out_ch.data;
      if (expected_counts_q.size() == 0) begin
        if (failures < MAX_REPORTS)
          $display("%0t: unexpected word, expected none, actual %p", $time, got);
        failures++;
      end else begin
        exp_r = expected_counts_q.pop_front();
        words_checked++;
        check_field("coded_bit_errors", exp_r.coded_bit_errors, got.coded_bit_errors);
        check_field("decoded_bits", exp_r.decoded_bits, got.decoded_bits);
        check_field("block_errors", exp_r.block_errors, got.block_errors);
        check_field("decoded_blocks", exp_r.decoded_blocks, got.decoded_blocks);
        check_field("raw_bit_errors", exp_r.raw_bit_errors, got.raw_bit_errors);
        check_field("raw_bits", exp_r.raw_bits, got.raw_bits);
        check_field("errors_this_item", RESULT_W'(exp_r.errors_this_item),
                    RESULT_W'(got.errors_this_item));
      end
    end
  end

  // result side ready: long hold on request, random stall bursts otherwise
  initial begin
    out_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (stall_en && $urandom_range(0, 2) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
  end

  // watchdog on cycles without any accepted word
  always @(posedge clk) begin
    if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
        (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t: no word moved for %0d cycles", $time, idle_cycles);
      $display("Verification failed");
      $finish;
    end
  end

  // test sequence
  initial begin
    in_ch.valid <= 1'b0;
    in_ch.data  <= '0;
    rst_n       <= 1'b0;
    for (int k = 0; k < ENTRIES; k++) begin
      coded_err_tbl[k]  = '0;
      dec_bits_tbl[k]   = '0;
      blk_err_tbl[k]    = '0;
      dec_blocks_tbl[k] = '0;
      raw_err_tbl[k]    = '0;
      raw_bits_tbl[k]   = '0;
    end
    // busy slots for the random traffic, two of them at the table corners
    hot_addr[0] = '0;
    hot_addr[1] = '1;
    for (int i = 2; i < HOT_COUNT; i++) hot_addr[i] = ADDR_W'($urandom);
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    test_directed_events();
    test_output_hold();
    test_random_traffic(1570);
    test_large_amounts();

    $display("%0d words sent, %0d results checked, %0d mismatching fields",
             words_sent, words_checked, failures);
    $display("covered every opcode, byte and symbol width corners, output hold-off and %s",
             "full-scale bit counts in one slot");
    if (failures == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

### filelist.f
hw/rtl/bbect_pkg.sv
hw/rtl/bbect_if.sv
hw/rtl/bbect_ram.sv
hw/rtl/bit_block_error_counter_table_unit.sv
bench/tb_bit_block_error_counter_table_unit.sv
